// File: rtl/phfu_pkg.sv
// Package for the pipeline hazard and forwarding unit.
// Holds the instruction class codes and the item and result structs.
// No dependencies.
`timescale 1ns / 1ps

package phfu_pkg;

  localparam int ClassWidth = 4;
  localparam int RegWidth   = 5;

  localparam logic [ClassWidth-1:0] CL_NOP   = 4'd0;
  localparam logic [ClassWidth-1:0] CL_HALT  = 4'd1;
  localparam logic [ClassWidth-1:0] CL_RTYPE = 4'd2;
  localparam logic [ClassWidth-1:0] CL_SHIFT = 4'd3;
  localparam logic [ClassWidth-1:0] CL_LUI   = 4'd4;
  localparam logic [ClassWidth-1:0] CL_STORE = 4'd5;
  localparam logic [ClassWidth-1:0] CL_ITYPE = 4'd6;
  localparam logic [ClassWidth-1:0] CL_BEQ   = 4'd7;
  localparam logic [ClassWidth-1:0] CL_BNE   = 4'd8;
  localparam logic [ClassWidth-1:0] CL_BGTZ  = 4'd9;
  localparam logic [ClassWidth-1:0] CL_J     = 4'd10;
  localparam logic [ClassWidth-1:0] CL_JAL   = 4'd11;
  localparam logic [ClassWidth-1:0] CL_JR    = 4'd12;

  typedef logic [RegWidth-1:0] reg_num_t;

  typedef struct packed {
    logic [ClassWidth-1:0] decode_class;
    reg_num_t              decode_rs;
    reg_num_t              decode_rt;
    logic [ClassWidth-1:0] execute_class;
    reg_num_t              execute_rs;
    reg_num_t              execute_rt;
    logic                  execute_is_load;
    reg_num_t              execute_dest;
    logic                  memory_is_load;
    reg_num_t              memory_dest;
    reg_num_t              writeback_dest;
  } hazard_item_t;

  typedef struct packed {
    logic stall_res;
    logic branch_fwd_rs;
    logic branch_fwd_rt;
    logic alu_fwd_rs;
    logic alu_rs_from_wb;
    logic alu_fwd_rt;
    logic alu_rt_from_wb;
  } hazard_res_t;

  // Codes above the last defined class behave as a nop.
  function automatic logic [ClassWidth-1:0] norm_class(input logic [ClassWidth-1:0] c);
    norm_class = (c > CL_JR) ? CL_NOP : c;
  endfunction

endpackage

// File: rtl/pipeline_hazard_forwarding_unit_top.sv
// Top level of the pipeline hazard and forwarding unit.
// Input transactions pass through the input register and then the result register.
// Throughput: one transaction per cycle unless stalled; the decision logic between the two
// registers is a handful of 5-bit compares, and in_stall follows out_stall in the same cycle
// when both full. Reset: synchronous active-high rst empties both stages; no other state.
// Depends on phfu_pkg and phfu_logic.
`timescale 1ns / 1ps

module pipeline_hazard_forwarding_unit_top import phfu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ClassWidth-1:0] decode_class,
  input  logic [RegWidth-1:0]   decode_rs,
  input  logic [RegWidth-1:0]   decode_rt,
  input  logic [ClassWidth-1:0] execute_class,
  input  logic [RegWidth-1:0]   execute_rs,
  input  logic [RegWidth-1:0]   execute_rt,
  input  logic                  execute_is_load,
  input  logic [RegWidth-1:0]   execute_dest,
  input  logic                  memory_is_load,
  input  logic [RegWidth-1:0]   memory_dest,
  input  logic [RegWidth-1:0]   writeback_dest,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  stall_res,
  output logic                  branch_fwd_rs,
  output logic                  branch_fwd_rt,
  output logic                  alu_fwd_rs,
  output logic                  alu_rs_from_wb,
  output logic                  alu_fwd_rt,
  output logic                  alu_rt_from_wb
);

  hazard_item_t item_reg;
  logic         item_valid;
  hazard_res_t  res_next;
  hazard_res_t  res_reg;
  logic         res_advance;
  logic         item_advance;

  assign res_advance  = !out_valid || !out_stall;
  assign item_advance = !item_valid || res_advance;
  assign in_stall     = !item_advance;

  phfu_logic u_logic (
    .item (item_reg),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (item_advance) begin
      item_valid <= in_valid;
    end
    if (item_advance && in_valid) begin
      item_reg <= '{decode_class:    decode_class,
                    decode_rs:       decode_rs,
                    decode_rt:       decode_rt,
                    execute_class:   execute_class,
                    execute_rs:      execute_rs,
                    execute_rt:      execute_rt,
                    execute_is_load: execute_is_load,
                    execute_dest:    execute_dest,
                    memory_is_load:  memory_is_load,
                    memory_dest:     memory_dest,
                    writeback_dest:  writeback_dest};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_advance) begin
      out_valid <= item_valid;
    end
    if (res_advance && item_valid) begin
      res_reg <= res_next;
    end
  end

  assign stall_res      = res_reg.stall_res;
  assign branch_fwd_rs  = res_reg.branch_fwd_rs;
  assign branch_fwd_rt  = res_reg.branch_fwd_rt;
  assign alu_fwd_rs     = res_reg.alu_fwd_rs;
  assign alu_rs_from_wb = res_reg.alu_rs_from_wb;
  assign alu_fwd_rt     = res_reg.alu_fwd_rt;
  assign alu_rt_from_wb = res_reg.alu_rt_from_wb;

endmodule

// File: rtl/phfu_logic.sv
// Combinational hazard detection and forwarding decision for one cycle.
// Depends on phfu_pkg for the class codes and the item and result structs.
`timescale 1ns / 1ps

module phfu_logic import phfu_pkg::*; (
  input  hazard_item_t item,
  output hazard_res_t  res
);

  logic [ClassWidth-1:0] dcl;
  logic [ClassWidth-1:0] ecl;
  logic d_branch, d_idle, d_rd_rs, d_rd_rt, d_exec_rt;
  logic e_rd_rs, e_rd_rt;
  logic mem_fwd_ok, wb_valid;
  logic frs_mem, frt_mem;

  always_comb begin
    dcl = norm_class(item.decode_class);
    ecl = norm_class(item.execute_class);

    d_branch  = (dcl >= CL_BEQ) && (dcl <= CL_JR);
    d_idle    = (dcl == CL_NOP) || (dcl == CL_HALT);
    d_rd_rs   = (dcl == CL_BEQ) || (dcl == CL_BNE) || (dcl == CL_BGTZ) || (dcl == CL_JR);
    d_rd_rt   = (dcl == CL_BEQ) || (dcl == CL_BNE);
    d_exec_rt = (dcl == CL_RTYPE) || (dcl == CL_SHIFT) || (dcl == CL_STORE);

    e_rd_rs = !((ecl == CL_NOP) || (ecl == CL_HALT)) && !((ecl >= CL_BEQ) && (ecl <= CL_JR))
              && (ecl != CL_SHIFT) && (ecl != CL_LUI);
    e_rd_rt = (ecl == CL_RTYPE) || (ecl == CL_SHIFT) || (ecl == CL_STORE);

    mem_fwd_ok = !item.memory_is_load && (item.memory_dest != '0);
    wb_valid   = item.writeback_dest != '0;

    res = '0;

    if (d_branch) begin
      res.branch_fwd_rs = mem_fwd_ok && d_rd_rs && (item.memory_dest == item.decode_rs);
      res.branch_fwd_rt = mem_fwd_ok && d_rd_rt && (item.memory_dest == item.decode_rt);
      res.stall_res =
        ((item.execute_dest != '0) &&
         ((d_rd_rs && (item.execute_dest == item.decode_rs)) ||
          (d_rd_rt && (item.execute_dest == item.decode_rt)))) ||
        (item.memory_is_load && (item.memory_dest != '0) &&
         ((d_rd_rs && (item.memory_dest == item.decode_rs)) ||
          (d_rd_rt && (item.memory_dest == item.decode_rt))));
    end else if (!d_idle) begin
      // Load-use: the loaded value is not ready until after the memory stage.
      res.stall_res = item.execute_is_load && (item.execute_dest != '0) &&
                      ((item.execute_dest == item.decode_rs) ||
                       ((item.execute_dest == item.decode_rt) && d_exec_rt));
    end

    frs_mem = mem_fwd_ok && e_rd_rs && (item.memory_dest == item.execute_rs);
    frt_mem = mem_fwd_ok && e_rd_rt && (item.memory_dest == item.execute_rt);

    res.alu_fwd_rs = frs_mem;
    res.alu_fwd_rt = frt_mem;

    // When MEM/WB matches rs, rt is never taken from MEM/WB in the same cycle.
    if (wb_valid) begin
      if (item.writeback_dest == item.execute_rs) begin
        if (e_rd_rs && !frs_mem) begin
          res.alu_fwd_rs     = 1'b1;
          res.alu_rs_from_wb = 1'b1;
        end
      end else if (item.writeback_dest == item.execute_rt) begin
        if (e_rd_rt && !frt_mem) begin
          res.alu_fwd_rt     = 1'b1;
          res.alu_rt_from_wb = 1'b1;
        end
      end
    end
  end

endmodule
